/* hdl/cpp_pkg.sv */
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types, constants and helpers for the capped cylinder projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpp_pkg;

	// coordinate range of the results; outputs never wider than 32 bits
	localparam int COORD_WIDTH = 32;
	localparam int SAT_W       = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
	localparam longint SAT_HI_L = (longint'(1) <<< (SAT_W - 1)) - longint'(1);
	localparam logic signed [33:0] SAT_HI = 34'(SAT_HI_L);
	localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

	// pipeline depths of the root and divide units
	localparam int ROOT_STAGES = 32;
	localparam int DIV_STAGES  = 33;

	// configuration port
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_BOT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_TOP  = 2'd2;

	localparam logic [30:0]        RADIUS_RST = 31'd65536;
	localparam logic signed [31:0] Z_BOT_RST  = 32'sd0;
	localparam logic signed [31:0] Z_TOP_RST  = 32'sd65536;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [30:0]        margin;
	} in_t;

	typedef struct packed {
		logic signed [31:0] proj_x;
		logic signed [31:0] proj_y;
		logic signed [31:0] proj_z;
		logic               is_inside;
		logic               ball_inside;
	} out_t;

	// clamp to the signed coordinate range
	function automatic logic [31:0] sat_coord(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = v;
		if (v > SAT_HI)
			r = SAT_HI;
		else if (v < SAT_LO)
			r = SAT_LO;
		return r[31:0];
	endfunction

	// magnitude with sign, then clamp
	function automatic logic [31:0] signed_sat(input logic neg, input logic [32:0] mag);
		logic signed [33:0] v;
		v = $signed({1'b0, mag});
		if (neg)
			v = -v;
		return sat_coord(v);
	endfunction

endpackage

`default_nettype wire

/* hdl/cylinder_point_projection_top.sv */
// ----------------------------------------------------------------------------
// cylinder_point_projection_top
// Nearest point on a closed Z-axis cylinder, with inside and ball-inside flags.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction | meaning
//  in      | in_valid, in_ready, in_data    | sink      | point and margin
//  out     | out_valid, out_ready, out_data | source    | projected point, flags
//  cfg     | cfg_wr_en, cfg_idx, cfg_wdata  | sink      | radius, bottom, top
//
// One point per cycle while in_ready is high; the 32-stage root pipe and the
// 33-stage divider lie in series between accept and out_valid.
// Async reset clears valid bits, the skid stage and the config registers.
// A stalled output parks in a skid register; in_ready drops only while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module cylinder_point_projection_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire cpp_pkg::in_t                  in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output cpp_pkg::out_t                      out_data,
	input  wire logic                          cfg_wr_en,
	input  wire logic [cpp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [cpp_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int RN = cpp_pkg::ROOT_STAGES;
	localparam int DN = cpp_pkg::DIV_STAGES;

	localparam logic [1:0] MODE_KEEP  = 2'd0;
	localparam logic [1:0] MODE_SCALE = 2'd1;
	localparam logic [1:0] MODE_AXIS  = 2'd2;

	typedef struct packed {
		logic [31:0]        ax;
		logic [31:0]        ay;
		logic               sx;
		logic               sy;
		logic [1:0]         mode;
		logic signed [31:0] pz;
		logic               in_cyl;
		logic               ball;
	} side_t;

	// configuration
	logic [30:0]        radius_q;
	logic signed [31:0] z_bot_q;
	logic signed [31:0] z_top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= cpp_pkg::RADIUS_RST;
			z_bot_q  <= cpp_pkg::Z_BOT_RST;
			z_top_q  <= cpp_pkg::Z_TOP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				cpp_pkg::CFG_RADIUS: radius_q <= cfg_wdata[30:0];
				cpp_pkg::CFG_Z_BOT:  z_bot_q  <= $signed(cfg_wdata);
				cpp_pkg::CFG_Z_TOP:  z_top_q  <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	logic en;
	logic skid_v_q;
	cpp_pkg::out_t skid_q;

	assign en       = !skid_v_q;
	assign in_ready = en;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic rv_s [RN];
	logic dv_s [DN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			for (int i = 0; i < RN; i++) rv_s[i] <= 1'b0;
			for (int i = 0; i < DN; i++) dv_s[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			rv_s[0] <= v_s5;
			for (int i = 1; i < RN; i++) rv_s[i] <= rv_s[i-1];
			v_s6 <= rv_s[RN-1];
			v_s7 <= v_s6;
			dv_s[0] <= v_s7;
			for (int i = 1; i < DN; i++) dv_s[i] <= dv_s[i-1];
			v_s8 <= dv_s[DN-1];
		end
	end

	// s1: input register
	logic signed [31:0] x_s1, y_s1, z_s1;
	logic [30:0]        m_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= in_data.pos_x;
			y_s1 <= in_data.pos_y;
			z_s1 <= in_data.pos_z;
			m_s1 <= in_data.margin;
		end
	end

	// s2: magnitudes, Z tests, distances to the caps
	logic [31:0]        ax_s2, ay_s2;
	logic               sx_s2, sy_s2, zgt_s2, zlt_s2, mler_s2;
	logic signed [32:0] tdist_s2, bdist_s2;
	logic signed [31:0] z_s2;
	logic [30:0]        d_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s2    <= x_s1[31] ? 32'(-x_s1) : 32'(x_s1);
			ay_s2    <= y_s1[31] ? 32'(-y_s1) : 32'(y_s1);
			sx_s2    <= x_s1[31];
			sy_s2    <= y_s1[31];
			zgt_s2   <= z_s1 > z_top_q;
			zlt_s2   <= z_s1 < z_bot_q;
			tdist_s2 <= {z_top_q[31], z_top_q} - {z_s1[31], z_s1};
			bdist_s2 <= {z_s1[31], z_s1} - {z_bot_q[31], z_bot_q};
			mler_s2  <= m_s1 <= radius_q;
			d_s2     <= radius_q - m_s1;
			z_s2     <= z_s1;
		end
	end

	// s3: squares
	logic [63:0]        axx_s3, ayy_s3;
	logic [61:0]        d2_s3, r2_s3;
	logic signed [33:0] dt_s3, db_s3;
	logic [31:0]        ax_s3, ay_s3;
	logic               sx_s3, sy_s3, zgt_s3, zlt_s3, mler_s3;
	logic signed [31:0] z_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			axx_s3  <= ax_s2 * ax_s2;
			ayy_s3  <= ay_s2 * ay_s2;
			d2_s3   <= d_s2 * d_s2;
			r2_s3   <= radius_q * radius_q;
			dt_s3   <= $signed({3'b000, radius_q}) - {tdist_s2[32], tdist_s2};
			db_s3   <= $signed({3'b000, radius_q}) - {bdist_s2[32], bdist_s2};
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			sx_s3   <= sx_s2;
			sy_s3   <= sy_s2;
			zgt_s3  <= zgt_s2;
			zlt_s3  <= zlt_s2;
			mler_s3 <= mler_s2;
			z_s3    <= z_s2;
		end
	end

	// s4: radial square and cap thresholds (dt/db fit 31 bits whenever positive in Z range)
	logic [63:0]        n2_s4;
	logic [61:0]        dt2_s4, db2_s4, d2_s4, r2_s4;
	logic               dtpos_s4, dbpos_s4;
	logic [31:0]        ax_s4, ay_s4;
	logic               sx_s4, sy_s4, zgt_s4, zlt_s4, mler_s4;
	logic signed [31:0] z_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			n2_s4    <= axx_s3 + ayy_s3;
			dt2_s4   <= dt_s3[30:0] * dt_s3[30:0];
			db2_s4   <= db_s3[30:0] * db_s3[30:0];
			dtpos_s4 <= dt_s3 > 34'sd0;
			dbpos_s4 <= db_s3 > 34'sd0;
			d2_s4    <= d2_s3;
			r2_s4    <= r2_s3;
			ax_s4    <= ax_s3;
			ay_s4    <= ay_s3;
			sx_s4    <= sx_s3;
			sy_s4    <= sy_s3;
			zgt_s4   <= zgt_s3;
			zlt_s4   <= zlt_s3;
			mler_s4  <= mler_s3;
			z_s4     <= z_s3;
		end
	end

	// s5: case decision
	logic        inz, outr, captop, capbot, onaxis;
	logic [1:0]  mode_c;
	logic signed [31:0] pz_c;

	always_comb begin
		inz    = !zgt_s4 && !zlt_s4;
		outr   = n2_s4 > {2'b00, r2_s4};
		captop = inz && !outr && dtpos_s4 && (n2_s4 < {2'b00, dt2_s4});
		capbot = inz && !outr && !captop && dbpos_s4 && (n2_s4 < {2'b00, db2_s4});
		onaxis = n2_s4 == 64'd0;
		if (outr)
			mode_c = MODE_SCALE;
		else if (!inz || captop || capbot)
			mode_c = MODE_KEEP;
		else if (onaxis)
			mode_c = MODE_AXIS;
		else
			mode_c = MODE_SCALE;
		if (zgt_s4 || captop)
			pz_c = z_top_q;
		else if (zlt_s4 || capbot)
			pz_c = z_bot_q;
		else
			pz_c = z_s4;
	end

	side_t       side_s5;
	logic [63:0] n2_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5.ax     <= ax_s4;
			side_s5.ay     <= ay_s4;
			side_s5.sx     <= sx_s4;
			side_s5.sy     <= sy_s4;
			side_s5.mode   <= mode_c;
			side_s5.pz     <= pz_c;
			side_s5.in_cyl <= inz && !outr;
			side_s5.ball   <= inz && mler_s4 && (n2_s4 <= {2'b00, d2_s4});
			n2_s5          <= n2_s4;
		end
	end

	// radial distance
	logic [31:0] root;

	cpp_isqrt u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (n2_s5),
		.root (root)
	);

	side_t rside_s [RN];

	always_ff @(posedge clk) begin
		if (en) begin
			rside_s[0] <= side_s5;
			for (int i = 1; i < RN; i++) rside_s[i] <= rside_s[i-1];
		end
	end

	// s6: products with the radius
	side_t       side_s6;
	logic [31:0] n_s6;
	logic [62:0] mx_s6, my_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6 <= rside_s[RN-1];
			n_s6    <= root;
			mx_s6   <= rside_s[RN-1].ax * radius_q;
			my_s6   <= rside_s[RN-1].ay * radius_q;
		end
	end

	// s7: round-half-up bias
	side_t       side_s7;
	logic [31:0] n_s7;
	logic [62:0] dx_s7, dy_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_s6;
			n_s7    <= n_s6;
			dx_s7   <= mx_s6 + {32'd0, n_s6[31:1]};
			dy_s7   <= my_s6 + {32'd0, n_s6[31:1]};
		end
	end

	logic [32:0] qx, qy;

	cpp_div u_divx (
		.clk      (clk),
		.en       (en),
		.dividend (dx_s7),
		.divisor  (n_s7),
		.quotient (qx)
	);

	cpp_div u_divy (
		.clk      (clk),
		.en       (en),
		.dividend (dy_s7),
		.divisor  (n_s7),
		.quotient (qy)
	);

	side_t dside_s [DN];

	always_ff @(posedge clk) begin
		if (en) begin
			dside_s[0] <= side_s7;
			for (int i = 1; i < DN; i++) dside_s[i] <= dside_s[i-1];
		end
	end

	// s8: sign, select, saturate
	side_t         sd;
	cpp_pkg::out_t res_c;
	cpp_pkg::out_t out_s8;

	always_comb begin
		sd = dside_s[DN-1];
		case (sd.mode)
			MODE_SCALE: begin
				res_c.proj_x = cpp_pkg::signed_sat(sd.sx, qx);
				res_c.proj_y = cpp_pkg::signed_sat(sd.sy, qy);
			end
			MODE_AXIS: begin
				res_c.proj_x = cpp_pkg::signed_sat(1'b0, {2'b00, radius_q});
				res_c.proj_y = '0;
			end
			default: begin
				res_c.proj_x = cpp_pkg::signed_sat(sd.sx, {1'b0, sd.ax});
				res_c.proj_y = cpp_pkg::signed_sat(sd.sy, {1'b0, sd.ay});
			end
		endcase
		res_c.proj_z      = cpp_pkg::sat_coord({{2{sd.pz[31]}}, sd.pz});
		res_c.is_inside   = sd.in_cyl;
		res_c.ball_inside = sd.ball;
	end

	always_ff @(posedge clk) begin
		if (en)
			out_s8 <= res_c;
	end

	// skid stage: takes the result when the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en && v_s8 && !out_ready) begin
			skid_v_q <= 1'b1;
		end else if (skid_v_q && out_ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s8 && !out_ready)
			skid_q <= out_s8;
	end

	assign out_valid = skid_v_q || v_s8;
	assign out_data  = skid_v_q ? skid_q : out_s8;

endmodule

`default_nettype wire

/* hdl/cpp_isqrt.sv */
// ----------------------------------------------------------------------------
// cpp_isqrt
// Pipelined integer square root, floor(sqrt(rad)), one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_isqrt (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] rad,
	output logic [31:0]      root
);

	localparam int N = cpp_pkg::ROOT_STAGES;

	// index i is the register after stage i
	logic [32:0] rem_s  [1:N];
	logic [31:0] root_s [1:N];
	logic [63:0] rad_s  [1:N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [32:0] rem_in;
		logic [31:0] root_in;
		logic [63:0] rad_in;
		logic [34:0] rem_sh;
		logic [34:0] trial;
		logic        ge;
		logic [34:0] diff;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[i];
			assign root_in = root_s[i];
			assign rad_in  = rad_s[i];
		end

		always_comb begin
			rem_sh = {rem_in, rad_in[63:62]};
			trial  = {1'b0, root_in, 2'b01};
			ge     = rem_sh >= trial;
			diff   = rem_sh - trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? diff[32:0] : rem_sh[32:0];
				root_s[i+1] <= {root_in[30:0], ge};
				rad_s[i+1]  <= {rad_in[61:0], 2'b00};
			end
		end
	end

	assign root = root_s[N];

endmodule

`default_nettype wire

/* hdl/cpp_div.sv */
// ----------------------------------------------------------------------------
// cpp_div
// Pipelined restoring divider, 63-bit dividend by 32-bit divisor, 33-bit
// quotient, one quotient bit per stage. Quotient must fit in 33 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_div (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [62:0] dividend,
	input  wire logic [31:0] divisor,
	output logic [32:0]      quotient
);

	localparam int N = cpp_pkg::DIV_STAGES;

	logic [31:0] rem_s [1:N];
	logic [32:0] den_s [1:N];
	logic [32:0] quo_s [1:N];
	logic [31:0] dsr_s [1:N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [31:0] rem_in;
		logic [32:0] den_in;
		logic [32:0] quo_in;
		logic [31:0] dsr_in;
		logic [32:0] rem_sh;
		logic        ge;
		logic [32:0] diff;

		if (i == 0) begin : g_first
			// upper dividend bits are below the divisor when the quotient fits
			assign rem_in = {2'b00, dividend[62:33]};
			assign den_in = dividend[32:0];
			assign quo_in = '0;
			assign dsr_in = divisor;
		end else begin : g_next
			assign rem_in = rem_s[i];
			assign den_in = den_s[i];
			assign quo_in = quo_s[i];
			assign dsr_in = dsr_s[i];
		end

		always_comb begin
			rem_sh = {rem_in, den_in[32]};
			ge     = rem_sh >= {1'b0, dsr_in};
			diff   = rem_sh - {1'b0, dsr_in};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[31:0] : rem_sh[31:0];
				den_s[i+1] <= {den_in[31:0], 1'b0};
				quo_s[i+1] <= {quo_in[31:0], ge};
				dsr_s[i+1] <= dsr_in;
			end
		end
	end

	assign quotient = quo_s[N];

endmodule

`default_nettype wire

/* hdl/cpp_checker.sv */
// ----------------------------------------------------------------------------
// cpp_assert_checker
// Port-level checks for the cylinder projection block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_assert_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire cpp_pkg::out_t out_data
);

	// a pending result stays offered until its transaction completes
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped before transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("out_data changed while stalled");

	// input back-pressure only while a result is parked
	a_ready_skid: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no result waiting");

	// the ball fitting implies the centre is inside
	a_ball_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ball_inside |-> out_data.is_inside)
		else $error("ball_inside without is_inside");

endmodule

bind cylinder_point_projection_top cpp_assert_checker u_cpp_checker (.*);

`default_nettype wire

/* sim/cpp_checker.sv */
// ----------------------------------------------------------------------------
// cpp_checker
// Watches the point and result channels of the cylinder projection block,
// works out the projection for every accepted point from its own copy of the
// radius and Z bounds, and compares each result field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire cpp_pkg::in_t                  in_data,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire cpp_pkg::out_t                 out_data,
	input  wire logic                          cfg_wr_en,
	input  wire logic [cpp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [cpp_pkg::CFG_W-1:0]     cfg_wdata,
	output int                                 mismatches,
	output int                                 outstanding,
	output int                                 results_seen
);

	longint unsigned radius;
	longint          z_lo;
	longint          z_hi;
	cpp_pkg::out_t   projections[$];

	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// round half away from zero, sign of c kept
	function automatic longint scale_to_wall(input longint c, input longint unsigned r,
			input longint unsigned n);
		longint unsigned mag;
		longint unsigned q;
		mag = (c < 0) ? longint'(-c) : longint'(c);
		q = (mag * r + n / 2) / n;
		return (c < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [31:0] clamp_coord(input longint v);
		longint hi;
		longint lo;
		hi = longint'(cpp_pkg::SAT_HI);
		lo = longint'(cpp_pkg::SAT_LO);
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		return v[31:0];
	endfunction

	function automatic cpp_pkg::out_t project_point(input cpp_pkg::in_t p);
		cpp_pkg::out_t   o;
		longint          x, y, z, px, py, pz, dt, db;
		longint unsigned ax, ay, n2, r2, n, m, d;
		logic            in_z;
		x = longint'(p.pos_x);
		y = longint'(p.pos_y);
		z = longint'(p.pos_z);
		m = longint'({33'd0, p.margin});
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		n2 = ax * ax + ay * ay;
		r2 = radius * radius;
		n = floor_root(n2);
		px = x;
		py = y;
		pz = z;
		in_z = 1'b1;
		if (z > z_hi) begin
			pz = z_hi;
			in_z = 1'b0;
		end else if (z < z_lo) begin
			pz = z_lo;
			in_z = 1'b0;
		end
		if (n2 > r2) begin
			px = scale_to_wall(x, radius, n);
			py = scale_to_wall(y, radius, n);
		end else if (in_z) begin
			dt = longint'(radius) - (z_hi - z);
			db = longint'(radius) - (z - z_lo);
			if (dt > 0 && n2 < longint'(dt) * longint'(dt)) begin
				pz = z_hi;
			end else if (db > 0 && n2 < longint'(db) * longint'(db)) begin
				pz = z_lo;
			end else if (n == 0) begin
				// on the axis: pick the +X side of the wall
				px = longint'(radius);
				py = 0;
			end else begin
				px = scale_to_wall(x, radius, n);
				py = scale_to_wall(y, radius, n);
			end
		end
		o.proj_x = clamp_coord(px);
		o.proj_y = clamp_coord(py);
		o.proj_z = clamp_coord(pz);
		o.is_inside = (z >= z_lo && z <= z_hi) && (n2 <= r2);
		o.ball_inside = 1'b0;
		if (z >= z_lo && z <= z_hi && m <= radius) begin
			d = radius - m;
			o.ball_inside = (n2 <= d * d);
		end
		return o;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cpp_pkg::out_t want;
		if (!arst_n) begin
			radius <= longint'(cpp_pkg::RADIUS_RST);
			z_lo <= longint'(cpp_pkg::Z_BOT_RST);
			z_hi <= longint'(cpp_pkg::Z_TOP_RST);
			projections.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx)
					cpp_pkg::CFG_RADIUS: radius <= longint'({33'd0, cfg_wdata[30:0]});
					cpp_pkg::CFG_Z_BOT:  z_lo <= longint'($signed(cfg_wdata));
					cpp_pkg::CFG_Z_TOP:  z_hi <= longint'($signed(cfg_wdata));
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				projections.push_back(project_point(in_data));
			if (out_valid && out_ready) begin
				results_seen++;
				if (projections.size() == 0) begin
					$display("[%0t] result transaction with nothing expected", $realtime);
					mismatches++;
				end else begin
					want = projections.pop_front();
					if (out_data.proj_x !== want.proj_x)
						report("proj_x", out_data.proj_x, want.proj_x);
					if (out_data.proj_y !== want.proj_y)
						report("proj_y", out_data.proj_y, want.proj_y);
					if (out_data.proj_z !== want.proj_z)
						report("proj_z", out_data.proj_z, want.proj_z);
					if (out_data.is_inside !== want.is_inside)
						report("is_inside", out_data.is_inside, want.is_inside);
					if (out_data.ball_inside !== want.ball_inside)
						report("ball_inside", out_data.ball_inside, want.ball_inside);
				end
			end
			outstanding <= projections.size();
		end
	end

	initial begin
		mismatches = 0;
		results_seen = 0;
	end

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives points through the cylinder projection block under a range of radius
// and Z bound settings, with random gaps and output stalls; the checker does
// the comparing and this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	cpp_pkg::in_t                  in_data;
	logic                          out_valid;
	logic                          out_ready;
	cpp_pkg::out_t                 out_data;
	logic                          cfg_wr_en;
	logic [cpp_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [cpp_pkg::CFG_W-1:0]     cfg_wdata;
	int                            mismatches;
	int                            outstanding;
	int                            results_seen;
	int                            points_sent;
	int                            settings_used;
	logic                          steady;
	longint                        cur_radius;

	cylinder_point_projection_top uut (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_data, .cfg_wr_en, .cfg_idx, .cfg_wdata
	);

	cpp_checker chk (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.out_data, .cfg_wr_en, .cfg_idx, .cfg_wdata, .mismatches, .outstanding,
		.results_seen
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("timeout");
		$display("simulation failed");
		$finish;
	end

	// result side back-pressure
	initial begin
		int k;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			k = steady ? 0 : $urandom_range(0, 4);
			if (k > 0) begin
				out_ready <= 1'b0;
				repeat (k) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [30:0] m);
		int k;
		k = steady ? 0 : $urandom_range(0, 4);
		if (k > 0) begin
			in_valid <= 1'b0;
			repeat (k) @(negedge clk);
		end
		in_data <= '{pos_x: x, pos_y: y, pos_z: z, margin: m};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		points_sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (90) @(negedge clk);
	endtask

	// leaves the write enable high; the caller drops it after the last write
	task automatic write_reg(input logic [cpp_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	task automatic set_cylinder(input logic [30:0] r, input logic [31:0] zb,
			input logic [31:0] zt);
		drain();
		write_reg(cpp_pkg::CFG_RADIUS, {$urandom_range(0, 1) == 1, r});
		write_reg(cpp_pkg::CFG_Z_BOT, zb);
		write_reg(cpp_pkg::CFG_Z_TOP, zt);
		cfg_wr_en <= 1'b0;
		cur_radius = longint'(r);
		settings_used++;
	endtask

	// coordinate: full range, near the cylinder, or zero
	function automatic logic [31:0] pick_coord(input longint span);
		int sel;
		longint v;
		sel = $urandom_range(0, 9);
		if (sel < 3)
			return $urandom;
		if (sel == 3)
			return 32'd0;
		v = longint'($urandom) % (2 * span + 1) - span;
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic logic [30:0] pick_margin;
		int sel;
		sel = $urandom_range(0, 5);
		if (sel == 0)
			return 31'd0;
		if (sel == 1)
			return 31'($urandom);
		return 31'(cur_radius * longint'($urandom_range(0, 16)) / 16
			+ longint'($urandom_range(0, 3)));
	endfunction

	task automatic random_points(input int count, input longint zb, input longint zt);
		longint span, zmid, zspan;
		span = (cur_radius * 2 + 65536 > 64'h3fff_ffff) ? 64'h3fff_ffff
			: cur_radius * 2 + 65536;
		zmid = (zb + zt) / 2;
		zspan = ((zt > zb) ? zt - zb : zb - zt) + 65536;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			send_point(pick_coord(span), pick_coord(span),
				$urandom_range(0, 2) == 0 ? $urandom
				: 32'(zmid + longint'($signed(pick_coord(zspan))) / 2 * 3 / 2),
				pick_margin());
		end
		steady = 1'b0;
	endtask

	initial begin
		logic [30:0] r;
		logic [31:0] a, b;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_idx = cpp_pkg::CFG_RADIUS;
		cfg_wdata = '0;
		steady = 1'b0;
		points_sent = 0;
		settings_used = 1;
		cur_radius = 65536;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset settings: unit radius, Z 0..1
		send_point(0, 0, 32'h8000, 0);                     // axis, top cap
		send_point(32'h4000, 0, 32'h2000, 0);              // bottom cap
		send_point(32'h10000, 0, 32'h8000, 31'h1);         // on the wall
		send_point(32'h30000, 32'hfffc_0000, 32'h8000, 0); // radially outside
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
		send_point(0, 0, 32'hffff_0000, 0);                // below the bottom
		send_point(32'h2000, 32'h2000, 32'h8000, 31'h8000);
		send_point(32'h2000, 32'h2000, 32'h8000, 31'h10001); // margin above radius
		send_point(0, 0, 32'h10000, 31'h10000);

		// tall cylinder: axis point goes to the side wall
		set_cylinder(31'h10000, 32'hfffc_0000, 32'h40000);
		send_point(0, 0, 0, 0);
		send_point(32'h100, 32'hffff_ff00, 0, 31'h100);
		random_points(250, -262144, 262144);

		// zero radius
		set_cylinder(0, 32'hffff_0000, 32'h10000);
		send_point(0, 0, 0, 0);
		send_point(1, 0, 0, 0);
		send_point(32'hffff_ffff, 32'h7fff_ffff, 32'h20000, 0);
		random_points(200, -65536, 65536);

		// largest radius, full Z range
		set_cylinder(31'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_point(0, 0, 0, 0);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
		random_points(250, -2147483648, 2147483647);

		// bottom above top
		set_cylinder(31'h20000, 32'h30000, 32'hfffd_0000);
		send_point(0, 0, 0, 0);
		send_point(32'h10000, 0, 32'h40000, 0);
		send_point(32'h10000, 0, 32'hfffc_0000, 0);
		random_points(200, 196608, -196608);

		// flat disc, bottom equals top
		set_cylinder(31'h18000, 32'h8000, 32'h8000);
		send_point(32'h1000, 0, 32'h8000, 0);
		random_points(150, 32768, 32768);

		// random settings
		for (int s = 0; s < 4; s++) begin
			r = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(1, 32'h80000));
			a = 32'($signed($urandom_range(0, 32'h100000)) - 32'sh80000);
			b = a + $urandom_range(0, 32'h100000);
			set_cylinder(r, a, b);
			random_points(150, longint'($signed(a)), longint'($signed(b)));
		end

		drain();
		$display("%0d points sent, %0d results checked across %0d cylinder settings",
			points_sent, results_seen, settings_used);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
